// ===== src/gb5_pkg.sv =====
// Package for the 5x5 streaming Gaussian blur: sizes, register codes, the tap
// class table and the structs that pass between the controller, line store,
// kernel datapath and output queue. Depends on nothing.
package gb5_pkg;

	// Image and kernel geometry
	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int KERNEL_SIZE = 5;
	localparam int COEF_BITS   = 16;
	localparam int HALF        = KERNEL_SIZE / 2;
	localparam int STORE_ROWS  = KERNEL_SIZE - 1;

	// Widths
	localparam int PIX_W    = 8;
	localparam int DIM_W    = 11;
	localparam int DRAIN_W  = DIM_W + 1;
	localparam int COL_W    = $clog2(MAX_WIDTH);
	localparam int LANE_W   = $clog2(STORE_ROWS);
	localparam int PROD_W   = PIX_W + COEF_BITS;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Weight classes by squared distance: 0, 1, 2, 4, 5, 8
	localparam int NUM_CLASSES = 6;
	localparam int CLASS_W     = $clog2(NUM_CLASSES);

	// Output queue and the most results one input word can cause
	localparam int FIFO_DEPTH  = 16;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int MAX_RESULTS = 3;
	localparam int RES_W       = $clog2(FIFO_DEPTH + 1);
	localparam int RES_LIMIT   = FIFO_DEPTH - MAX_RESULTS;

	// Reset values of the configuration registers
	localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(512);
	localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(512);

	typedef logic [NUM_CLASSES-1:0][COEF_BITS-1:0] coef_set_t;

	localparam coef_set_t COEF_RESET = {
		16'd195, 16'd872, 16'd1438, 16'd3908, 16'd6444, 16'd10624
	};

	// Weight class of each tap, row by row
	localparam logic [CLASS_W-1:0] TAP_CLASS [KERNEL_SIZE][KERNEL_SIZE] = '{
		'{3'd5, 3'd4, 3'd3, 3'd4, 3'd5},
		'{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
		'{3'd3, 3'd1, 3'd0, 3'd1, 3'd3},
		'{3'd4, 3'd2, 3'd1, 3'd2, 3'd4},
		'{3'd5, 3'd4, 3'd3, 3'd4, 3'd5}
	};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COEF_CENTER  = 3'd0,
		REG_COEF_DIST1   = 3'd1,
		REG_COEF_DIST2   = 3'd2,
		REG_COEF_DIST4   = 3'd3,
		REG_COEF_DIST5   = 3'd4,
		REG_COEF_DIST8   = 3'd5,
		REG_IMAGE_WIDTH  = 3'd6,
		REG_IMAGE_HEIGHT = 3'd7
	} cfg_reg_t;

	// Input command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	// Controller sequencer states
	typedef enum logic [2:0] {
		SEQ_RUN,
		SEQ_EDGE1,
		SEQ_EDGE2,
		SEQ_PRE1,
		SEQ_PRE2
	} seq_state_t;

	// One line store word: the same column of all stored rows
	typedef logic [STORE_ROWS-1:0][PIX_W-1:0] line_word_t;

	// 5x5 window of pixels or floored products
	typedef logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][PIX_W-1:0] window_t;

	// Column shift operation issued by the controller
	typedef struct packed {
		logic                  valid;
		logic                  clear;
		logic                  emit;
		logic                  eor;
		logic                  eoi;
		logic [STORE_ROWS-1:0] mask;
		logic [LANE_W-1:0]     rot;
		logic [PIX_W-1:0]      lane4;
	} op_t;

	typedef struct packed {
		logic             en;
		logic [COL_W-1:0] addr;
	} mem_rd_t;

	typedef struct packed {
		logic              en;
		logic [LANE_W-1:0] lane;
		logic [COL_W-1:0]  addr;
		logic [PIX_W-1:0]  data;
	} mem_wr_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             eor;
		logic             eoi;
	} result_t;

endpackage

// ===== src/gb5_line_mem.sv =====
// Line store: one synchronous memory holding four image rows, one word per
// column with a byte lane per row. Uses gb5_pkg for sizes and port structs.
module gb5_line_mem
	import gb5_pkg::*;
(
	input  logic       clk,
	input  mem_rd_t    rd,
	input  mem_wr_t    wr,
	output line_word_t rd_data
);

	line_word_t mem [MAX_WIDTH];

	// Byte-lane write; a read of the same word returns its old contents
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr][wr.lane] <= wr.data;
		end
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

// ===== src/gb5_ctrl.sv =====
// Controller: row, column and drain counters, the line store addressing and
// the sequencer for row-end and drain-preload steps. Uses gb5_pkg.
module gb5_ctrl
	import gb5_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_command,
	input  logic [PIX_W-1:0] in_pixel,
	output logic             in_ready,
	input  logic [DIM_W-1:0] width,
	input  logic [DIM_W-1:0] height,
	input  logic             pop,
	output op_t              op,
	output mem_rd_t          rd,
	output mem_wr_t          wr
);

	localparam int T_W = DIM_W + 1;
	localparam int M_W = T_W + 1;

	seq_state_t            state_q, state_d;
	logic [DIM_W-1:0]      row_q, row_d;
	logic [DIM_W-1:0]      col_q, col_d;
	logic [DRAIN_W-1:0]    drain_q, drain_d;
	logic [STORE_ROWS-1:0] seq_mask_q, seq_mask_d;
	logic [LANE_W-1:0]     seq_rot_q, seq_rot_d;
	logic                  seq_eoi_q, seq_eoi_d;
	logic [RES_W-1:0]      reserved_q, reserved_d;

	logic                  accept;
	logic                  pix_act, pix_last, pix_emit;
	logic [DIM_W-1:0]      rows_left;
	logic [DRAIN_W-1:0]    total;
	logic                  q_row;
	logic [DRAIN_W-1:0]    ocol_w;
	logic [DIM_W-1:0]      ocol;
	logic [DIM_W:0]        drn_col;
	logic                  drn_in, drn_act, drn_done;
	logic [T_W-1:0]        t_pix, t_drn;
	logic [STORE_ROWS-1:0] mask_pix, mask_drn;

	// Rows of the window column that exist: row t-4+i must lie in 0..h-1
	function automatic logic [STORE_ROWS-1:0] row_mask(
		input logic [T_W-1:0]   t,
		input logic [DIM_W-1:0] h
	);
		logic [STORE_ROWS-1:0] m;
		logic [M_W-1:0]        ti;
		m = '0;
		for (int i = 0; i < STORE_ROWS; i++) begin
			ti = M_W'(t) + M_W'(i);
			m[i] = (ti >= M_W'(STORE_ROWS)) && (ti < M_W'(h) + M_W'(STORE_ROWS));
		end
		return m;
	endfunction

	// Pixel word decode
	assign pix_act  = (row_q < height) && (col_q < DIM_W'(MAX_WIDTH));
	assign pix_last = ({1'b0, col_q} + 1'b1) >= {1'b0, width};
	assign pix_emit = (row_q >= DIM_W'(HALF)) && (col_q >= DIM_W'(HALF));
	assign t_pix    = T_W'(row_q);
	assign mask_pix = row_mask(t_pix, height);

	// Drain word decode: the count stays below twice the width
	assign rows_left = (height < DIM_W'(HALF)) ? height : DIM_W'(HALF);
	assign total     = (height >= DIM_W'(HALF)) ? ({1'b0, width} << 1) : {1'b0, width};
	assign q_row     = drain_q >= {1'b0, width};
	assign ocol_w    = q_row ? (drain_q - {1'b0, width}) : drain_q;
	assign ocol      = ocol_w[DIM_W-1:0];
	assign drn_col   = {1'b0, ocol} + (DIM_W + 1)'(HALF);
	assign drn_in    = drn_col < {1'b0, width};
	assign drn_act   = (row_q >= height) && (drain_q < total);
	assign drn_done  = (drain_q + 1'b1) >= total;
	assign t_drn     = T_W'(height) - T_W'(rows_left) + T_W'(q_row) + T_W'(HALF);
	assign mask_drn  = row_mask(t_drn, height);

	// Sequencer and counter update
	always_comb begin
		state_d    = state_q;
		row_d      = row_q;
		col_d      = col_q;
		drain_d    = drain_q;
		seq_mask_d = seq_mask_q;
		seq_rot_d  = seq_rot_q;
		seq_eoi_d  = seq_eoi_q;
		op         = '0;
		rd         = '0;
		wr         = '0;
		in_ready   = (state_q == SEQ_RUN) && (reserved_q <= RES_W'(RES_LIMIT));
		accept     = in_valid && in_ready;

		case (state_q)
			SEQ_RUN: begin
				if (accept && (in_command == CMD_PIXEL) && pix_act) begin
					op.valid = 1'b1;
					op.clear = (col_q == '0);
					op.emit  = pix_emit;
					op.eor   = !pix_last;
					op.mask  = mask_pix;
					op.rot   = t_pix[LANE_W-1:0];
					op.lane4 = in_pixel;
					rd.en    = 1'b1;
					rd.addr  = col_q[COL_W-1:0];
					wr.en    = 1'b1;
					wr.lane  = row_q[LANE_W-1:0];
					wr.addr  = col_q[COL_W-1:0];
					wr.data  = in_pixel;
					if (pix_last) begin
						col_d = '0;
						row_d = row_q + 1'b1;
						if (pix_emit) begin
							state_d = SEQ_EDGE1;
						end
					end else begin
						col_d = col_q + 1'b1;
					end
				end else if (accept && (in_command == CMD_DRAIN) && drn_act) begin
					op.valid = 1'b1;
					op.rot   = t_drn[LANE_W-1:0];
					rd.en    = 1'b1;
					if (ocol == '0) begin
						// Start of an output row: load columns 0 and 1 first
						op.clear   = 1'b1;
						op.mask    = mask_drn;
						rd.addr    = '0;
						seq_mask_d = mask_drn;
						seq_rot_d  = t_drn[LANE_W-1:0];
						seq_eoi_d  = drn_done;
						state_d    = SEQ_PRE1;
					end else begin
						op.emit = 1'b1;
						op.eor  = 1'b1;
						op.eoi  = drn_done;
						op.mask = drn_in ? mask_drn : '0;
						rd.addr = drn_col[COL_W-1:0];
					end
					if (drn_done) begin
						row_d   = '0;
						col_d   = '0;
						drain_d = '0;
					end else begin
						drain_d = drain_q + 1'b1;
					end
				end
			end
			SEQ_EDGE1: begin
				// Right edge: shift in a zero column
				op.valid = 1'b1;
				op.emit  = 1'b1;
				state_d  = SEQ_EDGE2;
			end
			SEQ_EDGE2: begin
				op.valid = 1'b1;
				op.emit  = 1'b1;
				op.eor   = 1'b1;
				state_d  = SEQ_RUN;
			end
			SEQ_PRE1: begin
				op.valid = 1'b1;
				op.mask  = seq_mask_q;
				op.rot   = seq_rot_q;
				rd.en    = 1'b1;
				rd.addr  = COL_W'(1);
				state_d  = SEQ_PRE2;
			end
			SEQ_PRE2: begin
				op.valid = 1'b1;
				op.emit  = 1'b1;
				op.eor   = 1'b1;
				op.eoi   = seq_eoi_q;
				op.mask  = seq_mask_q;
				op.rot   = seq_rot_q;
				rd.en    = 1'b1;
				rd.addr  = COL_W'(HALF);
				state_d  = SEQ_RUN;
			end
			default: begin
				state_d = SEQ_RUN;
			end
		endcase

		// Results in flight or queued
		reserved_d = reserved_q + RES_W'(op.valid && op.emit) - RES_W'(pop);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= SEQ_RUN;
			row_q      <= '0;
			col_q      <= '0;
			drain_q    <= '0;
			seq_mask_q <= '0;
			seq_rot_q  <= '0;
			seq_eoi_q  <= 1'b0;
			reserved_q <= '0;
		end else begin
			state_q    <= state_d;
			row_q      <= row_d;
			col_q      <= col_d;
			drain_q    <= drain_d;
			seq_mask_q <= seq_mask_d;
			seq_rot_q  <= seq_rot_d;
			seq_eoi_q  <= seq_eoi_d;
			reserved_q <= reserved_d;
		end
	end

endmodule

// ===== src/gb5_kernel.sv =====
// Kernel datapath: builds the new window column from the line store word,
// shifts the 5x5 window, multiplies all taps and sums them over two stages.
// Uses gb5_pkg for the op struct, window type and tap class table.
module gb5_kernel
	import gb5_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  op_t        op,
	input  line_word_t rd_data,
	input  coef_set_t  coef,
	output logic       push,
	output result_t    result
);

	op_t                                 op_s1;
	logic [KERNEL_SIZE-1:0][PIX_W-1:0]   col;
	window_t                             win_q, win_d;
	logic                                valid_s2, eor_s2, eoi_s2;
	window_t                             prod, prod_s3;
	logic                                valid_s3, eor_s3, eoi_s3;
	logic [KERNEL_SIZE-1:0][PIX_W-1:0]   rowsum, rowsum_s4;
	logic                                valid_s4, eor_s4, eoi_s4;
	logic [PIX_W-1:0]                    total;

	// New column: stored rows rotated into place, masked, then the pixel
	always_comb begin
		logic [LANE_W-1:0] lane;
		lane = '0;
		for (int i = 0; i < STORE_ROWS; i++) begin
			lane = op_s1.rot + LANE_W'(i);
			col[i] = op_s1.mask[i] ? rd_data[lane] : '0;
		end
		col[KERNEL_SIZE-1] = op_s1.lane4;
	end

	// Window shift, with an optional clear of the older columns
	always_comb begin
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
				win_d[i][j] = op_s1.clear ? '0 : win_q[i][j+1];
			end
			win_d[i][KERNEL_SIZE-1] = col[i];
		end
	end

	// Tap products, each floored to its integer part
	always_comb begin
		logic [PROD_W-1:0] full;
		full = '0;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				full = PROD_W'(win_q[i][j]) * PROD_W'(coef[TAP_CLASS[i][j]]);
				prod[i][j] = full[PROD_W-1:COEF_BITS];
			end
		end
	end

	// Row sums, kept to the low byte
	always_comb begin
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			rowsum[i] = '0;
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				rowsum[i] = rowsum[i] + prod_s3[i][j];
			end
		end
	end

	// Final sum of the row sums
	always_comb begin
		total = '0;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			total = total + rowsum_s4[i];
		end
	end

	assign push         = valid_s4;
	assign result.pixel = total;
	assign result.eor   = eor_s4;
	assign result.eoi   = eoi_s4;

	// Control pipeline and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1    <= '0;
			win_q    <= '0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			op_s1    <= op;
			if (op_s1.valid) begin
				win_q <= win_d;
			end
			valid_s2 <= op_s1.valid && op_s1.emit;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Data pipeline
	always_ff @(posedge clk) begin
		eor_s2    <= op_s1.eor;
		eoi_s2    <= op_s1.eoi;
		prod_s3   <= prod;
		eor_s3    <= eor_s2;
		eoi_s3    <= eoi_s2;
		rowsum_s4 <= rowsum;
		eor_s4    <= eor_s3;
		eoi_s4    <= eoi_s3;
	end

endmodule

// ===== src/gb5_out_fifo.sv =====
// Output queue: holds finished result words so the input side keeps moving
// while the output side stalls. Uses gb5_pkg for the result struct and depth.
module gb5_out_fifo
	import gb5_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    out_ready,
	output logic    out_valid,
	output result_t out_data,
	output logic    pop
);

	result_t            entries [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign out_valid = (count_q != '0);
	assign out_data  = entries[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// Storage; the controller never lets it overflow
	always_ff @(posedge clk) begin
		if (push) begin
			entries[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

// ===== src/gaussian_blur_5x5_stream.sv =====
// Top level of the streaming 5x5 Gaussian blur: configuration registers and
// the connection of controller, line store, kernel datapath and output queue.
// Depends on gb5_pkg, gb5_ctrl, gb5_line_mem, gb5_kernel and gb5_out_fifo.
//
// Pixels enter in raster order on the slave stream, one word per clock when the
// input is not stalled; the word at (r,c) gives the blurred pixel at (r-2,c-2).
// From the third row on, the word that closes a row is followed by the states
// SEQ_EDGE1 and SEQ_EDGE2, since the two right-edge results are formed by
// shifting zero columns through the window; a drain word that starts an output
// row is followed by SEQ_PRE1 and SEQ_PRE2, reading columns 0, 1 and 2 from the
// line store in turn, and no input is taken in these states. The line store is
// one 1024 x 32-bit memory, one byte lane per buffered row, read and written once
// per cycle; its contents are not cleared after reset, so no clearing pass is
// needed. A 16-word output queue decouples the two streams; the input stalls when
// more than thirteen results are in flight or queued. Configuration writes are
// always taken and should be made only while no image is being processed.
module gaussian_blur_5x5_stream
	import gb5_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIX_W-1:0]      s_axis_tdata,   // [7:0] pixel_in
	input  logic                  s_axis_tuser,   // [0] command
	// Output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIX_W-1:0]      m_axis_tdata,   // [7:0] blurred_pixel
	output logic                  m_axis_tlast,   // end_of_run
	output logic                  m_axis_tuser    // [0] end_of_image
);

	coef_set_t        coef_q;
	logic [DIM_W-1:0] width_q, height_q;
	logic [DIM_W-1:0] width_eff, height_eff;
	op_t              op;
	mem_rd_t          rd;
	mem_wr_t          wr;
	line_word_t       rd_data;
	logic             push, pop;
	result_t          push_data, head;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= COEF_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_COEF_CENTER, REG_COEF_DIST1, REG_COEF_DIST2,
				REG_COEF_DIST4, REG_COEF_DIST5, REG_COEF_DIST8: begin
					coef_q[cfg_index] <= cfg_data[COEF_BITS-1:0];
				end
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[DIM_W-1:0];
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[DIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Image size clamped to the supported range
	assign width_eff = (width_q < DIM_W'(KERNEL_SIZE)) ? DIM_W'(KERNEL_SIZE) :
		(width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign height_eff = (height_q == '0) ? DIM_W'(1) :
		(height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

	gb5_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_command (s_axis_tuser),
		.in_pixel   (s_axis_tdata),
		.in_ready   (s_axis_tready),
		.width      (width_eff),
		.height     (height_eff),
		.pop        (pop),
		.op         (op),
		.rd         (rd),
		.wr         (wr)
	);

	gb5_line_mem u_line_mem (
		.clk     (clk),
		.rd      (rd),
		.wr      (wr),
		.rd_data (rd_data)
	);

	gb5_kernel u_kernel (
		.clk     (clk),
		.arst_n  (arst_n),
		.op      (op),
		.rd_data (rd_data),
		.coef    (coef_q),
		.push    (push),
		.result  (push_data)
	);

	gb5_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (head),
		.pop       (pop)
	);

	assign m_axis_tdata = head.pixel;
	assign m_axis_tlast = head.eor;
	assign m_axis_tuser = head.eoi;

endmodule
